// File: design/sws_pkg.sv
package sws_pkg;

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int MC_W    = 7;
    localparam int DIST_W  = 34;
    localparam int NORM_W  = 17;
    localparam int WGT_W   = 28;
    localparam int OBJ_W   = 35;
    localparam int LO_W    = 17;
    localparam int PROD_W  = LO_W + WGT_W;

    localparam logic [MC_W-1:0]    MC_RESET   = 7'd64;
    localparam logic [11:0]        WEIGHT_Q16 = 12'd3277;
    localparam logic [DIST_W-1:0]  ONE_Q8     = 34'd256;
    localparam logic signed [SCORE_W-1:0] SCORE_HI = 16'sh7FFF;
    localparam logic signed [SCORE_W-1:0] SCORE_LO = 16'sh8000;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_DECIDE,
        ST_LIST,
        ST_N_RD,
        ST_N_INIT,
        ST_N_DIV,
        ST_N_WR,
        ST_C_RD,
        ST_C_DIFF,
        ST_C_SQ,
        ST_C_CMP,
        ST_F_RD,
        ST_F_EMIT,
        ST_A_RD,
        ST_A_DIFF,
        ST_A_SQ,
        ST_A_UPD,
        ST_B_RD,
        ST_B_M1,
        ST_B_M2,
        ST_B_CMP,
        ST_EMIT
    } state_t;

endpackage

// File: design/sws_ram.sv
module sws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/score_weighted_spread_select.sv
// Channel   Direction  tdata                                        tuser     tlast
// s_        in         pos_x [15:0], pos_y [31:16], score [47:32]   score_ok  final_point
// m_        out        chosen_index [5:0], zero padding [7:6]       -         final_pick
// cfg_wr_*  in         max_count [6:0], written when cfg_wr_en is high
//
// Points load one a cycle while s_tready is high; a transaction with tlast closes the set.
// A set of m points with m above max_count first gets score normalisation
// (17-step serial divider per point) or a centroid search, then each further pick makes
// two passes over the point RAMs. Otherwise every point is listed in order.
// Reset is synchronous on aresetn low; stored points need no clearing.
// A stalled m_ side holds the sequencer at its next result; s_tready is low until selection ends.
module score_weighted_spread_select
    import sws_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,   // pos_x, pos_y, score
    input  logic             s_tuser,   // score_ok
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // chosen_index, zero padding
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic [MC_W-1:0]  cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = COORD_W + CNT_W;
    localparam int SQ_W  = SUM_W + 1;
    localparam int D_W   = 2 * SQ_W - 1;

    state_t state_reg, state_next;

    logic [MC_W-1:0]           mcfg_reg, mc_reg, mc_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      ok_reg, ok_next;
    logic signed [SCORE_W-1:0] smin_reg, smin_next, smax_reg, smax_next;
    logic [SUM_W-1:0]          sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [4:0]                step_reg, step_next;
    logic [NORM_W-1:0]         rem_reg, rem_next, q_reg, q_next, bnorm_reg, bnorm_next;
    logic [IDX_W-1:0]          first_reg, first_next;
    logic signed [SQ_W-1:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic [D_W-1:0]            sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [D_W:0]              cbest_reg, cbest_next;
    logic [DIST_W-1:0]         ndold_reg, ndold_next, dmax_reg, dmax_next;
    logic [CNT_W-1:0]          k_reg, k_next;
    logic [COORD_W-1:0]        lastx_reg, lastx_next, lasty_reg, lasty_next;
    logic [COORD_W-1:0]        nx_reg, nx_next, ny_reg, ny_next;
    logic [COORD_W-1:0]        cx_reg, cx_next, cy_reg, cy_next;
    logic [DIST_W-1:0]         ndv_reg, ndv_next;
    logic [WGT_W-1:0]          w_reg, w_next;
    logic [PROD_W-1:0]         plo_reg, plo_next, phi_reg, phi_next;
    logic [OBJ_W-1:0]          bobj_reg, bobj_next;
    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          pick_reg, pick_next;
    logic [MAX_POINTS-1:0]     picked_reg, picked_next;
    logic                      mvalid_reg, mvalid_next, mlast_reg, mlast_next;
    logic [IDX_W-1:0]          midx_reg, midx_next;

    logic [COORD_W-1:0]        x_rd, y_rd;
    logic [SCORE_W-1:0]        s_rd;
    logic [WGT_W-1:0]          w_rd;
    logic [DIST_W-1:0]         nd_rd;
    logic [IDX_W-1:0]          rd_addr;
    logic                      w_we, nd_we;
    logic [WGT_W-1:0]          w_wdata;
    logic [DIST_W-1:0]         nd_wdata;

    logic acc, store_en, out_free, idx_at_end, norm_mode;
    logic [SCORE_W-1:0] span;
    logic [MC_W-1:0]    mc_eff;

    assign acc        = s_tvalid && s_tready;
    assign store_en   = acc && (count_reg < CNT_W'(MAX_POINTS));
    assign out_free   = !mvalid_reg || m_tready;
    assign idx_at_end = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign span       = SCORE_W'(smax_reg - smin_reg);
    assign norm_mode  = ok_reg && (smax_reg > smin_reg);
    assign mc_eff     = (mcfg_reg == '0) ? MC_W'(1) : mcfg_reg;

    sws_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_x_ram (
        .aclk(aclk), .we(store_en), .waddr(count_reg[IDX_W-1:0]),
        .wdata(s_tdata[15:0]), .raddr(rd_addr), .rdata(x_rd)
    );
    sws_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_y_ram (
        .aclk(aclk), .we(store_en), .waddr(count_reg[IDX_W-1:0]),
        .wdata(s_tdata[31:16]), .raddr(rd_addr), .rdata(y_rd)
    );
    sws_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_POINTS)) u_s_ram (
        .aclk(aclk), .we(store_en), .waddr(count_reg[IDX_W-1:0]),
        .wdata(s_tdata[47:32]), .raddr(rd_addr), .rdata(s_rd)
    );
    sws_ram #(.WIDTH(WGT_W), .DEPTH(MAX_POINTS)) u_w_ram (
        .aclk(aclk), .we(w_we), .waddr(idx_reg),
        .wdata(w_wdata), .raddr(rd_addr), .rdata(w_rd)
    );
    sws_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_nd_ram (
        .aclk(aclk), .we(nd_we), .waddr(idx_reg),
        .wdata(nd_wdata), .raddr(rd_addr), .rdata(nd_rd)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (acc && s_tlast) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (MC_W'(count_reg) <= mc_eff) state_next = ST_LIST;
                else if (norm_mode)             state_next = ST_N_RD;
                else                            state_next = ST_C_RD;
            end
            ST_LIST: begin
                if (out_free && idx_at_end) state_next = ST_LOAD;
            end
            ST_N_RD:   state_next = ST_N_INIT;
            ST_N_INIT: state_next = ST_N_DIV;
            ST_N_DIV: begin
                if (step_reg == 5'd16) state_next = ST_N_WR;
            end
            ST_N_WR:   state_next = idx_at_end ? ST_F_RD : ST_N_RD;
            ST_C_RD:   state_next = ST_C_DIFF;
            ST_C_DIFF: state_next = ST_C_SQ;
            ST_C_SQ:   state_next = ST_C_CMP;
            ST_C_CMP:  state_next = idx_at_end ? ST_F_RD : ST_C_RD;
            ST_F_RD:   state_next = ST_F_EMIT;
            ST_F_EMIT: begin
                if (out_free) state_next = (mc_reg == MC_W'(1)) ? ST_LOAD : ST_A_RD;
            end
            ST_A_RD:   state_next = ST_A_DIFF;
            ST_A_DIFF: state_next = ST_A_SQ;
            ST_A_SQ:   state_next = ST_A_UPD;
            ST_A_UPD:  state_next = idx_at_end ? ST_B_RD : ST_A_RD;
            ST_B_RD:   state_next = ST_B_M1;
            ST_B_M1:   state_next = ST_B_M2;
            ST_B_M2:   state_next = ST_B_CMP;
            ST_B_CMP:  state_next = idx_at_end ? ST_EMIT : ST_B_RD;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ((MC_W'(k_reg) + MC_W'(1)) == mc_reg) ? ST_LOAD : ST_A_RD;
                end
            end
            default:   state_next = ST_LOAD;
        endcase
    end

    // Memory controls.
    always_comb begin
        rd_addr  = idx_reg;
        w_we     = 1'b0;
        w_wdata  = '0;
        nd_we    = 1'b0;
        nd_wdata = '0;
        unique case (state_reg)
            ST_F_RD, ST_F_EMIT: rd_addr = first_reg;
            ST_N_WR: begin
                w_we    = 1'b1;
                w_wdata = WGT_W'(WEIGHT_Q16 * q_reg);
            end
            ST_C_CMP: w_we = 1'b1;
            ST_A_UPD: begin
                nd_we    = 1'b1;
                nd_wdata = ndv_next;
            end
            default: rd_addr = idx_reg;
        endcase
    end

    // Datapath.
    always_comb begin
        logic [NORM_W-1:0]      trial;
        logic                   ge;
        logic [SUM_W-1:0]       mx, my;
        logic [D_W:0]           dsum;
        logic [DIST_W-1:0]      d34;
        logic [COORD_W:0]       ddx, ddy;
        logic [PROD_W+LO_W-1:0] prod;
        logic [OBJ_W-1:0]       obj;
        logic                   clear_load;
        logic                   emit;
        logic [IDX_W-1:0]       emit_idx;
        logic                   emit_last;

        mc_next     = mc_reg;
        count_next  = count_reg;
        ok_next     = ok_reg;
        smin_next   = smin_reg;
        smax_next   = smax_reg;
        sumx_next   = sumx_reg;
        sumy_next   = sumy_reg;
        idx_next    = idx_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        bnorm_next  = bnorm_reg;
        first_next  = first_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sqx_next    = sqx_reg;
        sqy_next    = sqy_reg;
        cbest_next  = cbest_reg;
        ndold_next  = ndold_reg;
        dmax_next   = dmax_reg;
        k_next      = k_reg;
        lastx_next  = lastx_reg;
        lasty_next  = lasty_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        ndv_next    = ndv_reg;
        w_next      = w_reg;
        plo_next    = plo_reg;
        phi_next    = phi_reg;
        bobj_next   = bobj_reg;
        found_next  = found_reg;
        pick_next   = pick_reg;
        picked_next = picked_reg;
        clear_load  = 1'b0;
        emit        = 1'b0;
        emit_idx    = idx_reg;
        emit_last   = 1'b0;

        trial = (step_reg == 5'd0) ? rem_reg : {rem_reg[NORM_W-2:0], 1'b0};
        ge    = trial >= NORM_W'(span);
        mx    = SUM_W'(count_reg * x_rd);
        my    = SUM_W'(count_reg * y_rd);
        dsum  = (D_W+1)'(sqx_reg) + (D_W+1)'(sqy_reg);
        d34   = DIST_W'(dsum);
        ddx   = {1'b0, x_rd} - {1'b0, lastx_reg};
        ddy   = {1'b0, y_rd} - {1'b0, lasty_reg};
        prod  = {phi_reg, {LO_W{1'b0}}} + (PROD_W+LO_W)'(plo_reg);
        obj   = OBJ_W'(ndv_reg) + OBJ_W'(prod[PROD_W+LO_W-1:32]);

        unique case (state_reg)
            ST_LOAD: begin
                if (store_en) begin
                    count_next = count_reg + CNT_W'(1);
                    if ($signed(s_tdata[47:32]) < smin_reg) smin_next = $signed(s_tdata[47:32]);
                    if ($signed(s_tdata[47:32]) > smax_reg) smax_next = $signed(s_tdata[47:32]);
                    if (!s_tuser) ok_next = 1'b0;
                    sumx_next = sumx_reg + SUM_W'(s_tdata[15:0]);
                    sumy_next = sumy_reg + SUM_W'(s_tdata[31:16]);
                end
            end
            ST_DECIDE: begin
                mc_next     = mc_eff;
                idx_next    = '0;
                first_next  = '0;
                picked_next = '0;
            end
            ST_LIST: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = idx_at_end;
                    idx_next  = idx_reg + IDX_W'(1);
                    clear_load = idx_at_end;
                end
            end
            ST_N_INIT: begin
                rem_next  = NORM_W'($signed(s_rd) - smin_reg);
                q_next    = '0;
                step_next = '0;
            end
            ST_N_DIV: begin
                rem_next  = ge ? trial - NORM_W'(span) : trial;
                q_next    = {q_reg[NORM_W-2:0], ge};
                step_next = step_reg + 5'd1;
            end
            ST_N_WR: begin
                if (idx_reg == '0 || q_reg > bnorm_reg) begin
                    bnorm_next = q_reg;
                    first_next = idx_reg;
                end
                idx_next = idx_reg + IDX_W'(1);
            end
            ST_C_DIFF: begin
                dx_next = $signed({1'b0, mx}) - $signed({1'b0, sumx_reg});
                dy_next = $signed({1'b0, my}) - $signed({1'b0, sumy_reg});
            end
            ST_C_SQ, ST_A_SQ: begin
                sqx_next = D_W'(dx_reg * dx_reg);
                sqy_next = D_W'(dy_reg * dy_reg);
            end
            ST_C_CMP: begin
                if (idx_reg == '0 || dsum > cbest_reg) begin
                    cbest_next = dsum;
                    first_next = idx_reg;
                end
                idx_next = idx_reg + IDX_W'(1);
            end
            ST_F_EMIT: begin
                lastx_next = x_rd;
                lasty_next = y_rd;
                if (out_free) begin
                    emit        = 1'b1;
                    emit_idx    = first_reg;
                    emit_last   = mc_reg == MC_W'(1);
                    clear_load  = emit_last;
                    picked_next[first_reg] = 1'b1;
                    k_next      = CNT_W'(1);
                    idx_next    = '0;
                    dmax_next   = ONE_Q8;
                end
            end
            ST_A_DIFF: begin
                ndold_next = nd_rd;
                dx_next    = SQ_W'($signed(ddx));
                dy_next    = SQ_W'($signed(ddy));
            end
            ST_A_UPD: begin
                // The first round replaces the stale distances of an earlier set.
                ndv_next = (k_reg == CNT_W'(1) || d34 < ndold_reg) ? d34 : ndold_reg;
                if (ndv_next > dmax_reg) dmax_next = ndv_next;
                // The scoring pass starts again from the first point.
                idx_next   = idx_at_end ? '0 : idx_reg + IDX_W'(1);
                found_next = 1'b0;
            end
            ST_B_M1: begin
                ndv_next = nd_rd;
                w_next   = w_rd;
                cx_next  = x_rd;
                cy_next  = y_rd;
                plo_next = PROD_W'(dmax_reg[LO_W-1:0] * w_rd);
            end
            ST_B_M2: begin
                phi_next = PROD_W'(dmax_reg[DIST_W-1:LO_W] * w_reg);
            end
            ST_B_CMP: begin
                if (!picked_reg[idx_reg] && (!found_reg || obj > bobj_reg)) begin
                    bobj_next  = obj;
                    pick_next  = idx_reg;
                    nx_next    = cx_reg;
                    ny_next    = cy_reg;
                    found_next = 1'b1;
                end
                idx_next = idx_reg + IDX_W'(1);
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_idx   = pick_reg;
                    emit_last  = (MC_W'(k_reg) + MC_W'(1)) == mc_reg;
                    clear_load = emit_last;
                    picked_next[pick_reg] = 1'b1;
                    lastx_next = nx_reg;
                    lasty_next = ny_reg;
                    k_next     = k_reg + CNT_W'(1);
                    idx_next   = '0;
                    dmax_next  = ONE_Q8;
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase

        if (clear_load) begin
            count_next = '0;
            ok_next    = 1'b1;
            smin_next  = SCORE_HI;
            smax_next  = SCORE_LO;
            sumx_next  = '0;
            sumy_next  = '0;
        end

        mvalid_next = emit ? 1'b1 : (mvalid_reg && !m_tready);
        midx_next   = emit ? emit_idx : midx_reg;
        mlast_next  = emit ? emit_last : mlast_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            mcfg_reg   <= MC_RESET;
            count_reg  <= '0;
            ok_reg     <= 1'b1;
            smin_reg   <= SCORE_HI;
            smax_reg   <= SCORE_LO;
            sumx_reg   <= '0;
            sumy_reg   <= '0;
            picked_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            if (cfg_wr_en) mcfg_reg <= cfg_wr_data;
            count_reg  <= count_next;
            ok_reg     <= ok_next;
            smin_reg   <= smin_next;
            smax_reg   <= smax_next;
            sumx_reg   <= sumx_next;
            sumy_reg   <= sumy_next;
            picked_reg <= picked_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mc_reg    <= mc_next;
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        bnorm_reg <= bnorm_next;
        first_reg <= first_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        cbest_reg <= cbest_next;
        ndold_reg <= ndold_next;
        dmax_reg  <= dmax_next;
        k_reg     <= k_next;
        lastx_reg <= lastx_next;
        lasty_reg <= lasty_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ndv_reg   <= ndv_next;
        w_reg     <= w_next;
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        bobj_reg  <= bobj_next;
        found_reg <= found_next;
        pick_reg  <= pick_next;
        midx_reg  <= midx_next;
        mlast_reg <= mlast_next;
    end

    assign s_tready = state_reg == ST_LOAD;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = 8'(midx_reg);
    assign m_tlast  = mlast_reg;

endmodule

// File: design/sws_check.sv
module sws_check (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_tvalid,
    input logic            s_tready,
    input logic            s_tlast,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [7:0]      m_tdata,
    input logic            m_tlast
);

    // A waiting result must not change before it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A closing transaction always starts a selection, which stops input.
    a_close_stops_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after the set closed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:6] == 2'b00)
        else $error("padding bits of the result are not zero");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

endmodule

bind score_weighted_spread_select sws_check u_sws_check (.*);

// File: verif/testbench.sv
`timescale 1ns / 100ps

class sws_scoreboard;
    bit [15:0] xs[64];
    bit [15:0] ys[64];
    int        ss[64];
    int        count;
    bit        scores_ok;
    int        smin, smax;
    int        pick_limit;
    int        exp_index[$];
    bit        exp_last[$];
    int        errors;

    function void clear_set();
        count = 0;
        scores_ok = 1;
        smin = 32767;
        smax = -32768;
    endfunction

    function void init();
        pick_limit = 64;
        errors = 0;
        clear_set();
    endfunction

    function void push_pick(int idx, bit last);
        exp_index.insert(exp_index.size(), idx);
        exp_last.insert(exp_last.size(), last);
    endfunction

    function longint unsigned sq_dist(int a, int b);
        longint dx, dy;
        dx = longint'(xs[a]) - longint'(xs[b]);
        dy = longint'(ys[a]) - longint'(ys[b]);
        return longint'(dx * dx + dy * dy);
    endfunction

    function void choose_spread();
        int m, mc, first, last, nxt, i, k;
        longint unsigned norm[64];
        longint unsigned nearest[64];
        bit taken[64];
        longint unsigned span, dmax, best, obj;
        longint sx, sy, dx, dy, d, bestc;
        bit found;
        m = count;
        mc = (pick_limit == 0) ? 1 : pick_limit;
        first = 0;
        if (m == 0) return;
        if (m <= mc) begin
            for (i = 0; i < m; i++) push_pick(i, i + 1 == m);
            return;
        end
        for (i = 0; i < m; i++) begin
            norm[i] = 0;
            nearest[i] = 64'h3_FFFF_FFFF;
            taken[i] = 0;
        end
        if (scores_ok && smax > smin) begin
            span = smax - smin;
            for (i = 0; i < m; i++) norm[i] = (longint'(ss[i] - smin) << 16) / span;
            for (i = 1; i < m; i++) if (norm[i] > norm[first]) first = i;
        end else begin
            sx = 0;
            sy = 0;
            bestc = -1;
            for (i = 0; i < m; i++) begin
                sx += xs[i];
                sy += ys[i];
            end
            for (i = 0; i < m; i++) begin
                dx = longint'(m) * xs[i] - sx;
                dy = longint'(m) * ys[i] - sy;
                d = dx * dx + dy * dy;
                if (d > bestc) begin
                    bestc = d;
                    first = i;
                end
            end
        end
        taken[first] = 1;
        last = first;
        push_pick(first, mc == 1);
        for (k = 1; k < mc; k++) begin
            dmax = 256;
            best = 0;
            found = 0;
            nxt = 0;
            for (i = 0; i < m; i++) begin
                if (sq_dist(i, last) < nearest[i]) nearest[i] = sq_dist(i, last);
                if (nearest[i] != 64'h3_FFFF_FFFF && nearest[i] > dmax) dmax = nearest[i];
            end
            for (i = 0; i < m; i++) begin
                if (taken[i]) continue;
                obj = nearest[i] + ((dmax * 3277 * norm[i]) >> 32);
                if (!found || obj > best) begin
                    best = obj;
                    nxt = i;
                    found = 1;
                end
            end
            if (!found) begin
                exp_last[exp_last.size() - 1] = 1;
                return;
            end
            taken[nxt] = 1;
            last = nxt;
            push_pick(nxt, k + 1 == mc);
        end
    endfunction

    function void note_point(bit [47:0] data, bit ok, bit fin);
        int s;
        s = int'($signed(data[47:32]));
        if (count < 64) begin
            xs[count] = data[15:0];
            ys[count] = data[31:16];
            ss[count] = s;
            if (s < smin) smin = s;
            if (s > smax) smax = s;
            if (!ok) scores_ok = 0;
            count++;
        end
        if (fin) begin
            choose_spread();
            clear_set();
        end
    endfunction

    task report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    task check_pick(bit [7:0] data, bit last);
        int idx;
        bit el;
        if (exp_index.size() == 0) begin
            report($sformatf("unexpected pick %0d", data));
            return;
        end
        idx = exp_index.pop_front();
        el = exp_last.pop_front();
        if (data != idx) report($sformatf("index %0d, expected %0d", data, idx));
        if (last != el) report($sformatf("last flag %0d, expected %0d", last, el));
    endtask
endclass

module testbench;
    import sws_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;

    sws_scoreboard picks;
    int  cycle_count;
    int  calm_until;
    bit  hold_off;
    int  hold_len;

    score_weighted_spread_select u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function bit idle_now();
        return cycle_count >= calm_until && $urandom_range(99) < 17;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) picks.check_pick(m_tdata, m_tlast);
            if (hold_len > 0) begin
                hold_len <= hold_len - 1;
                m_tready <= 0;
            end else if (hold_off) begin
                hold_off <= 0;
                hold_len <= 3000;
                m_tready <= 0;
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    // The offer stays up after acceptance until the next point or idle cycle replaces it.
    task send_point(bit [15:0] x, bit [15:0] y, bit [15:0] s, bit ok, bit fin);
        while (idle_now()) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {s, y, x};
        s_tuser <= ok;
        s_tlast <= fin;
        do @(posedge aclk); while (!s_tready);
        picks.note_point({s, y, x}, ok, fin);
    endtask

    task drain_and_config(int value);
        s_tvalid <= 0;
        while (picks.exp_index.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= value[6:0];
        @(posedge aclk);
        cfg_wr_en <= 0;
        picks.pick_limit = value;
    endtask

    task random_set(int n);
        bit [15:0] base_x, base_y;
        for (int i = 0; i < n; i++) begin
            base_x = $urandom;
            base_y = $urandom;
            case ($urandom_range(3))
                0: send_point(base_x, base_y, $urandom, 1, i == n - 1);
                1: send_point(base_x & 16'h00FF, base_y & 16'h00FF,
                              $urandom_range(20), 1, i == n - 1);
                2: send_point(base_x, base_y, $urandom, $urandom_range(15) != 0, i == n - 1);
                default: send_point(base_x, base_y, 16'd5, 1, i == n - 1);
            endcase
        end
    endtask

    int sizes[6];
    int n;

    initial begin
        picks = new();
        picks.init();
        cycle_count = 0;
        calm_until = 0;
        hold_off = 0;
        hold_len = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        s_tlast = 0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, flat scores, an invalid score, and a set of one.
        drain_and_config(3);
        send_point(16'h0000, 16'h0000, 16'h8000, 1, 0);
        send_point(16'hFFFF, 16'hFFFF, 16'h7FFF, 1, 0);
        send_point(16'hFFFF, 16'h0000, 16'h0000, 1, 0);
        send_point(16'h0000, 16'hFFFF, 16'h1234, 1, 0);
        send_point(16'h8000, 16'h8000, 16'h0001, 1, 1);
        send_point(16'h0010, 16'h0020, 16'h0007, 1, 0);
        send_point(16'h0100, 16'h0020, 16'h0007, 1, 0);
        send_point(16'h0030, 16'h0900, 16'h0007, 1, 0);
        send_point(16'h0040, 16'h0040, 16'h0007, 1, 1);
        send_point(16'h1000, 16'h2000, 16'h7FFF, 0, 0);
        send_point(16'h3000, 16'h0500, 16'h0100, 1, 0);
        send_point(16'h0700, 16'h6000, 16'h8000, 1, 0);
        send_point(16'h5555, 16'hAAAA, 16'h0000, 1, 1);
        send_point(16'h1111, 16'h2222, 16'h0003, 1, 1);
        drain_and_config(0);
        send_point(16'h0001, 16'h0002, 16'h0003, 1, 0);
        send_point(16'hF000, 16'h0F00, 16'hFFFF, 1, 1);
        drain_and_config(1);
        send_point(16'h0202, 16'h0303, 16'h0011, 1, 0);
        send_point(16'h4040, 16'h5050, 16'h0022, 1, 1);

        // Full store: 70 points, the extra ones dropped.
        drain_and_config(64);
        random_set(70);
        drain_and_config(127);
        random_set(10);

        // Random sets over several settings; a stretch with no idling first.
        sizes = '{1, 5, 10, 64, 2, 30};
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_config(sizes[ph]);
            if (ph == 0) calm_until = cycle_count + 3000;
            if (ph == 2) hold_off <= 1;
            for (int r = 0; r < 4; r++) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 14);
                random_set(n);
            end
        end

        s_tvalid <= 0;
        while (picks.exp_index.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (picks.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
